FILE: src/axc_pkg.sv
// Shared types and constants for the two-sensor axle direction counter.
// Holds the transaction layouts, flag-state codes and register reset value.
// No dependencies.
`default_nettype none

package axc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned FlagW = 6;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 40;

  localparam logic [TimeW-1:0] TimeoutReset = TimeW'(10000000);

  // Flag-state codes: bit0 east level, bit1 west level, bit2 entered from east,
  // bit3 entered from west, bit4 staged westbound, bit5 staged eastbound
  localparam logic [FlagW-1:0] FsIdle        = 6'h00;
  localparam logic [FlagW-1:0] FsEastOnly    = 6'h01;
  localparam logic [FlagW-1:0] FsWestOnly    = 6'h02;
  localparam logic [FlagW-1:0] FsEntEast     = 6'h04;
  localparam logic [FlagW-1:0] FsEntWest     = 6'h08;
  localparam logic [FlagW-1:0] FsOverlapWb   = 6'h07;
  localparam logic [FlagW-1:0] FsOverlapEb   = 6'h0B;
  localparam logic [FlagW-1:0] FsTrailWb     = 6'h06;
  localparam logic [FlagW-1:0] FsTrailEb     = 6'h09;
  localparam logic [FlagW-1:0] FsStagedWb    = 6'h10;
  localparam logic [FlagW-1:0] FsStagedEb    = 6'h20;
  localparam logic [FlagW-1:0] FsBackWb      = 6'h11;
  localparam logic [FlagW-1:0] FsBackEb      = 6'h22;

  localparam logic DirWest = 1'b0;
  localparam logic DirEast = 1'b1;

  // Input transaction, first field in the highest bits
  typedef struct packed {
    logic             clear_interval;
    logic [TimeW-1:0] now_us;
    logic             sensor_east;
    logic             sensor_west;
  } axc_item_t;

  // Result transaction, first field in the highest bits
  typedef struct packed {
    logic             trip_indicator;
    logic [TimeW-1:0] interval_us;
    logic             travel_dir;
    logic             counted;
  } axc_result_t;

endpackage

`default_nettype wire

FILE: src/axc_in_stage.sv
// Input register for the axle counter: holds one accepted transaction.
// Depends on axc_pkg.
`default_nettype none

module axc_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire axc_pkg::axc_item_t item_i,
  input  wire logic              advance_i,
  output logic                   valid_o,
  output axc_pkg::axc_item_t     item_o
);
  import axc_pkg::*;

  logic      valid_q;
  axc_item_t item_q;

  // Take a new transaction when empty or when the held one moves on
  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: src/axc_core.sv
// Flag-state machine, speedometer interlocks and interval timing for one sample.
// Depends on axc_pkg.
`default_nettype none

module axc_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_wr_en_i,
  input  wire logic [axc_pkg::TimeW-1:0]  cfg_wr_data_i,
  input  wire logic                       step_i,
  input  wire axc_pkg::axc_item_t         item_i,
  output axc_pkg::axc_result_t            result_o
);
  import axc_pkg::*;

  logic [TimeW-1:0] timeout_q;
  logic [FlagW-1:0] flag_q, flag_d, flag_in;
  logic             trip_lock_q, trip_lock_d;
  logic             end_lock_q, end_lock_d;
  logic [TimeW-1:0] trip_start_q, trip_start_d;
  logic [TimeW-1:0] wheel_q, wheel_d, wheel_out;
  logic [TimeW-1:0] last_count_q, last_count_d;
  logic             dir_q, dir_d;
  logic             trip_q, trip_d;
  logic             counted;
  logic [TimeW-1:0] since_count;

  // Replace the sensor bits of the flag state with this sample
  assign flag_in = {flag_q[FlagW-1:2], item_i.sensor_west, item_i.sensor_east};

  // Decode the flag pattern
  always_comb begin
    flag_d       = flag_in;
    trip_lock_d  = trip_lock_q;
    end_lock_d   = end_lock_q;
    trip_start_d = trip_start_q;
    wheel_d      = wheel_q;
    last_count_d = last_count_q;
    dir_d        = dir_q;
    trip_d       = trip_q;
    counted      = 1'b0;
    unique case (flag_in)
      FsIdle: begin
        trip_lock_d = 1'b0;
        end_lock_d  = 1'b0;
      end
      FsEastOnly, FsWestOnly: begin
        flag_d = (flag_in == FsEastOnly) ? FsEntEast : FsEntWest;
        if (!trip_lock_q && !end_lock_q) begin
          trip_start_d = item_i.now_us;
          trip_d       = 1'b1;
          trip_lock_d  = 1'b1;
        end
      end
      FsEntEast, FsEntWest: begin
        flag_d      = FsIdle;
        trip_d      = 1'b0;
        trip_lock_d = 1'b0;
      end
      FsOverlapWb, FsOverlapEb: begin
        if (!end_lock_q && trip_lock_q) begin
          wheel_d = item_i.now_us - trip_start_q;
        end
        trip_d      = 1'b0;
        dir_d       = (flag_in == FsOverlapEb) ? DirEast : DirWest;
        trip_lock_d = 1'b0;
        end_lock_d  = 1'b1;
      end
      FsTrailWb: flag_d = FsStagedWb;
      FsTrailEb: flag_d = FsStagedEb;
      FsStagedWb, FsStagedEb: begin
        flag_d       = FsIdle;
        last_count_d = item_i.now_us;
        dir_d        = (flag_in == FsStagedEb) ? DirEast : DirWest;
        trip_lock_d  = 1'b0;
        end_lock_d   = 1'b0;
        counted      = 1'b1;
      end
      FsBackWb: flag_d = FsEntEast;
      FsBackEb: flag_d = FsEntWest;
      default: ;
    endcase
  end

  // Zero the interval after the idle timeout, then apply the clear request
  assign since_count = item_i.now_us - last_count_d;
  assign wheel_out   = (since_count > timeout_q) ? '0 : wheel_d;

  assign result_o = '{trip_indicator: trip_d,
                      interval_us:    wheel_out,
                      travel_dir:     dir_d,
                      counted:        counted};

  // Hold the timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_wr_en_i) begin
      timeout_q <= cfg_wr_data_i;
    end
  end

  // Advance the tracking state once per processed sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q       <= FsIdle;
      trip_lock_q  <= 1'b0;
      end_lock_q   <= 1'b0;
      trip_start_q <= '0;
      wheel_q      <= '0;
      last_count_q <= '0;
      dir_q        <= DirWest;
      trip_q       <= 1'b0;
    end else if (step_i) begin
      flag_q       <= flag_d;
      trip_lock_q  <= trip_lock_d;
      end_lock_q   <= end_lock_d;
      trip_start_q <= trip_start_d;
      wheel_q      <= item_i.clear_interval ? '0 : wheel_out;
      last_count_q <= last_count_d;
      dir_q        <= dir_d;
      trip_q       <= trip_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/axc_out_stage.sv
// Result register for the axle counter: holds one transaction until taken.
// Depends on axc_pkg.
`default_nettype none

module axc_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire axc_pkg::axc_result_t result_i,
  output logic                     can_load_o,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output axc_pkg::axc_result_t     result_o
);
  import axc_pkg::*;

  logic        valid_q;
  axc_result_t result_q;

  // Free when empty or when the held result is taken this cycle
  assign can_load_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

FILE: src/two_sensor_axle_direction_counter_unit.sv
// Two-sensor axle direction counter: top level with stream ports.
// Datapath: input register, then combinational core, then result register; m_axis_tready can stall either.
// Throughput: one transaction per cycle while m_axis_tready stays high; flag state updates once per transaction.
// Reset (rst_ni low, asynchronous): flag state, interlocks and timestamps clear to zero,
// idle timeout returns to 10000000 us. Depends on axc_pkg, axc_in_stage, axc_core, axc_out_stage.
`default_nettype none

module two_sensor_axle_direction_counter_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_wr_en_i,
  input  wire logic [axc_pkg::TimeW-1:0]     cfg_wr_data_i,   // idle_timeout_us
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] sensor_west, [1] sensor_east, [33:2] now_us, [34] clear_interval, rest zero
  input  wire logic [axc_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [0] counted, [1] travel_dir, [33:2] interval_us, [34] trip_indicator, rest zero
  output logic [axc_pkg::OutDataW-1:0]       m_axis_tdata
);
  import axc_pkg::*;

  localparam int unsigned ItemW   = $bits(axc_item_t);
  localparam int unsigned ResultW = $bits(axc_result_t);

  axc_item_t   in_item, held_item;
  axc_result_t step_result, out_result;
  logic        held_valid, out_can_load, advance;

  assign in_item = axc_item_t'(s_axis_tdata[ItemW-1:0]);

  // Move the held sample through the core when the result register frees up
  assign advance = held_valid && out_can_load;

  axc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  axc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .step_i        (advance),
    .item_i        (held_item),
    .result_o      (step_result)
  );

  axc_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .result_i   (step_result),
    .can_load_o (out_can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .result_o   (out_result)
  );

  // Pad the result to whole bytes
  assign m_axis_tdata = {{(OutDataW-ResultW){1'b0}}, out_result};

endmodule

`default_nettype wire
